@@ rtl/core/atsf_pkg.sv @@
// ----------------------------------------------------------------------------
// atsf_pkg
// Shared types and constants of the three-point surround filter: widths,
// saturation bounds, controller states and the controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package atsf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int A3_W     = 18;
  localparam int D3_W     = 28;
  localparam int ACC_W    = 38;
  localparam int CFG_W    = 10;
  localparam int DIFF_W   = 18;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Register indexes on the configuration port.
  localparam logic REG_IGNORE_COUNT = 1'b0;
  localparam logic REG_SCALE_FACTOR = 1'b1;

  localparam logic [CFG_W-1:0] IGNORE_COUNT_RESET = 10'd4;
  localparam logic [CFG_W-1:0] SCALE_FACTOR_RESET = 10'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SHORT,
    ST_ACC_PREV,
    ST_EMIT_PREV,
    ST_FORM_LAST,
    ST_ACC_LAST,
    ST_DIV_START,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic take_in;
    logic skip_inc;
    logic first_keep;
    logic form_prev;
    logic form_last;
    logic acc_step;
    logic kept_inc;
    logic shift;
    logic div_start;
    logic load_prev;
    logic load_last;
    logic load_short;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic skip_lt;
    logic kept_zero;
    logic in_last;
    logic out_busy;
    logic div_busy;
  } status_t;

endpackage

`default_nettype wire

@@ rtl/core/asl_three_point_surround_filter.sv @@
// ----------------------------------------------------------------------------
// asl_three_point_surround_filter
// Streams voxel time series and produces the three-point surround sum and the
// sign-alternating scaled second difference, with the series mean at the end.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                  Payload
//   input    in         in_valid / in_ready        sample, last_of_series
//   output   out        out_valid / out_ready      a3_value, d3_value, avg_d3,
//                                                  is_last, short_series
//   config   in/out     psel, penable, pwrite      paddr, pwdata, prdata
//
// A kept sample after the first is accepted, decided, accumulated and
// emitted in turn, the last step once its result register is free. The
// final sample of a series then forms and accumulates the last result and
// starts the restoring divider that forms the mean one quotient bit per
// cycle over the 38-bit accumulator. A dropped sample or the first kept one
// is accepted and decided; a series that ends short also loads a short beat.
// Reset is synchronous and clears the sequencer, the series state and the
// output valid; the registers return to ignore_count 4 and scale_factor 1.
// A stalled output holds its beat; the sequencer waits for the register to
// drain before it loads the next beat and takes no new sample meanwhile.
`default_nettype none

module asl_three_point_surround_filter
  import atsf_pkg::*;
#(
  parameter int MAX_SERIES_LEN = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // Input samples.
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic                       last_of_series,
  // Filter results.
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [A3_W-1:0]          a3_value,
  output logic signed [D3_W-1:0]          d3_value,
  output logic signed [D3_W-1:0]          avg_d3,
  output logic                            is_last,
  output logic                            short_series,
  // Configuration port.
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [2:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [CFG_W-1:0] ignore_count;
  logic [CFG_W-1:0] scale_factor;
  logic             cfg_write;
  cmd_t             cmd;
  status_t          status;

  // The port never stalls. Register i sits at byte address 4*i, so bit 2 of
  // the address picks the register and the low bits are ignored.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      ignore_count <= IGNORE_COUNT_RESET;
      scale_factor <= SCALE_FACTOR_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_IGNORE_COUNT) begin
        ignore_count <= pwdata[CFG_W-1:0];
      end else begin
        scale_factor <= pwdata[CFG_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_SCALE_FACTOR) ? 32'(scale_factor) : 32'(ignore_count);

  // The sequencer only issues commands; all state of the series lives in the
  // datapath, including the output register that parts the two sides.
  atsf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  atsf_datapath #(.MAX_SERIES_LEN(MAX_SERIES_LEN)) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .ignore_count   (ignore_count),
    .scale_factor   (scale_factor),
    .sample         (sample),
    .last_of_series (last_of_series),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .a3_value       (a3_value),
    .d3_value       (d3_value),
    .avg_d3         (avg_d3),
    .is_last        (is_last),
    .short_series   (short_series)
  );

endmodule

`default_nettype wire

@@ rtl/core/atsf_divider.sv @@
// ----------------------------------------------------------------------------
// atsf_divider
// Restoring divider, one quotient bit per cycle: magnitude of the signed
// accumulator divided by the unsigned kept count.
// ----------------------------------------------------------------------------
`default_nettype none

module atsf_divider
  import atsf_pkg::*;
#(
  parameter int KW = 11
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [ACC_W-1:0] dividend,
  input  wire logic [KW-1:0]           divisor,
  output logic                         busy,
  output logic                         negative,
  output logic [ACC_W-1:0]             quotient
);

  localparam int CW = $clog2(ACC_W + 1);

  logic [KW-1:0] rem;
  logic [CW-1:0] cnt;
  logic [KW:0]   shifted;
  logic [KW:0]   trial;
  logic          fits;

  assign shifted = {rem, quotient[ACC_W-1]};
  assign trial   = shifted - {1'b0, divisor};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(ACC_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      negative <= dividend[ACC_W-1];
      quotient <= dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
    end else if (busy) begin
      rem      <= fits ? trial[KW-1:0] : shifted[KW-1:0];
      quotient <= {quotient[ACC_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/atsf_datapath.sv @@
// ----------------------------------------------------------------------------
// atsf_datapath
// Series state, the filter arithmetic, the saturating accumulator, the mean
// divider and the output register, all driven by controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module atsf_datapath
  import atsf_pkg::*;
#(
  parameter int MAX_SERIES_LEN = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire cmd_t                       cmd,
  output status_t                         status,
  input  wire logic [CFG_W-1:0]           ignore_count,
  input  wire logic [CFG_W-1:0]           scale_factor,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic                       last_of_series,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [A3_W-1:0]          a3_value,
  output logic signed [D3_W-1:0]          d3_value,
  output logic signed [D3_W-1:0]          avg_d3,
  output logic                            is_last,
  output logic                            short_series
);

  localparam int KW = $clog2(MAX_SERIES_LEN + 1);
  localparam logic [KW-1:0] KEPT_MAX = KW'(MAX_SERIES_LEN);

  logic signed [SAMPLE_W-1:0] older;
  logic signed [SAMPLE_W-1:0] newer;
  logic signed [SAMPLE_W-1:0] in_x;
  logic                       in_last;
  logic [CFG_W-1:0]           skip_counter;
  logic [KW-1:0]              kept_count;
  logic                       sign_negative;
  logic signed [ACC_W-1:0]    d3_accumulator;
  logic signed [A3_W-1:0]     a3_r;
  logic signed [D3_W-1:0]     prod_r;
  logic signed [D3_W-1:0]     d3_r;
  logic                       interior_r;

  logic                       two_point;
  logic signed [DIFF_W-1:0]   o18, n18, x18;
  logic signed [A3_W-1:0]     a3_calc;
  logic signed [DIFF_W-1:0]   diff_calc;
  logic signed [D3_W:0]       prod_calc;
  logic signed [D3_W-1:0]     d3_calc;
  logic signed [ACC_W:0]      acc_sum;
  logic signed [ACC_W-1:0]    acc_sat;

  logic                       div_busy;
  logic                       div_neg;
  logic [ACC_W-1:0]           div_quo;
  logic signed [D3_W-1:0]     avg_sat;

  // The last position always uses the two-point form, as does the first one.
  assign two_point = cmd.form_last || (kept_count == KW'(1));
  assign o18 = DIFF_W'(older);
  assign n18 = DIFF_W'(newer);
  assign x18 = DIFF_W'(in_x);
  assign a3_calc   = two_point ? (n18 + x18) <<< 1 : o18 + (n18 <<< 1) + x18;
  assign diff_calc = two_point ? n18 - x18 : o18 - (n18 <<< 1) + x18;
  assign prod_calc = diff_calc * $signed({1'b0, scale_factor});

  assign d3_calc = sign_negative ? -prod_r : prod_r;
  assign acc_sum = (ACC_W+1)'(d3_accumulator) + (ACC_W+1)'(d3_calc);
  always_comb begin
    if (acc_sum > (ACC_W+1)'(ACC_MAX)) begin
      acc_sat = ACC_MAX;
    end else if (acc_sum < (ACC_W+1)'(ACC_MIN)) begin
      acc_sat = ACC_MIN;
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end
  end

  atsf_divider #(.KW(KW)) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (d3_accumulator),
    .divisor  (kept_count),
    .busy     (div_busy),
    .negative (div_neg),
    .quotient (div_quo)
  );

  // Clamp the truncated mean to the signed result width.
  always_comb begin
    if (!div_neg && div_quo > ACC_W'({1'b0, {(D3_W-1){1'b1}}})) begin
      avg_sat = {1'b0, {(D3_W-1){1'b1}}};
    end else if (div_neg && div_quo > ACC_W'({1'b1, {(D3_W-1){1'b0}}})) begin
      avg_sat = {1'b1, {(D3_W-1){1'b0}}};
    end else if (div_neg) begin
      avg_sat = -div_quo[D3_W-1:0];
    end else begin
      avg_sat = div_quo[D3_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      older          <= '0;
      newer          <= '0;
      skip_counter   <= '0;
      kept_count     <= '0;
      sign_negative  <= 1'b0;
      d3_accumulator <= '0;
    end else begin
      if (cmd.skip_inc) begin
        skip_counter <= skip_counter + 1'b1;
      end
      if (cmd.first_keep) begin
        sign_negative <= ~ignore_count[0];
        newer         <= in_x;
        kept_count    <= KW'(1);
      end
      if (cmd.acc_step) begin
        d3_accumulator <= acc_sat;
        if (interior_r) begin
          sign_negative <= ~sign_negative;
        end
      end
      if (cmd.kept_inc && kept_count < KEPT_MAX) begin
        kept_count <= kept_count + 1'b1;
      end
      if (cmd.shift) begin
        older <= newer;
        newer <= in_x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      in_x    <= sample;
      in_last <= last_of_series;
    end
    if (cmd.form_prev || cmd.form_last) begin
      a3_r       <= a3_calc;
      prod_r     <= prod_calc[D3_W-1:0];
      interior_r <= ~two_point;
    end
    if (cmd.acc_step) begin
      d3_r <= d3_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_prev || cmd.load_last || cmd.load_short) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_short) begin
      a3_value     <= '0;
      d3_value     <= '0;
      avg_d3       <= '0;
      is_last      <= 1'b1;
      short_series <= 1'b1;
    end else if (cmd.load_prev || cmd.load_last) begin
      a3_value     <= a3_r;
      d3_value     <= d3_r;
      avg_d3       <= cmd.load_last ? avg_sat : '0;
      is_last      <= cmd.load_last;
      short_series <= 1'b0;
    end
  end

  assign status.skip_lt   = skip_counter < ignore_count;
  assign status.kept_zero = kept_count == '0;
  assign status.in_last   = in_last;
  assign status.out_busy  = out_valid;
  assign status.div_busy  = div_busy;

endmodule

`default_nettype wire

@@ rtl/core/atsf_ctrl.sv @@
// ----------------------------------------------------------------------------
// atsf_ctrl
// Sequencer of the surround filter: steps each accepted sample through skip,
// first keep or filtering and emission; a series ends in the mean or a short beat.
// ----------------------------------------------------------------------------
`default_nettype none

module atsf_ctrl
  import atsf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_next  = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status.skip_lt) begin
          cmd.skip_inc = 1'b1;
          state_next   = status.in_last ? ST_SHORT : ST_IDLE;
        end else if (status.kept_zero) begin
          cmd.first_keep = 1'b1;
          state_next     = status.in_last ? ST_SHORT : ST_IDLE;
        end else begin
          cmd.form_prev = 1'b1;
          state_next    = ST_ACC_PREV;
        end
      end
      ST_SHORT: begin
        if (!status.out_busy) begin
          cmd.load_short = 1'b1;
          cmd.clear      = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_ACC_PREV: begin
        cmd.acc_step = 1'b1;
        state_next   = ST_EMIT_PREV;
      end
      ST_EMIT_PREV: begin
        if (!status.out_busy) begin
          cmd.load_prev = 1'b1;
          cmd.kept_inc  = 1'b1;
          if (status.in_last) begin
            state_next = ST_FORM_LAST;
          end else begin
            cmd.shift  = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_FORM_LAST: begin
        cmd.form_last = 1'b1;
        state_next    = ST_ACC_LAST;
      end
      ST_ACC_LAST: begin
        cmd.acc_step = 1'b1;
        state_next   = ST_DIV_START;
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (!status.div_busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!status.out_busy) begin
          cmd.load_last = 1'b1;
          cmd.clear     = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/atsf_checker.sv @@
// ----------------------------------------------------------------------------
// atsf_checker
// Port-level checks of the surround filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module atsf_checker
  import atsf_pkg::*;
(
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic signed [A3_W-1:0]     a3_value,
  input wire logic signed [D3_W-1:0]     d3_value,
  input wire logic signed [D3_W-1:0]     avg_d3,
  input wire logic                       is_last,
  input wire logic                       short_series
);

  // A stalled beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  // A short series reports a single, all-zero final beat.
  a_short_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && short_series |-> is_last && a3_value == '0 && d3_value == '0
      && avg_d3 == '0)
    else $error("short series beat is not an empty final beat");

  // The mean and the short flag appear only on the final beat.
  a_avg_only_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_last |-> avg_d3 == '0 && !short_series)
    else $error("mean or short flag on a beat that is not final");

  // Every accepted sample is worked on before the next one is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample accepted while the previous one is in flight");

endmodule

bind asl_three_point_surround_filter atsf_checker u_atsf_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .a3_value     (a3_value),
  .d3_value     (d3_value),
  .avg_d3       (avg_d3),
  .is_last      (is_last),
  .short_series (short_series)
);

`default_nettype wire
